// ===== rtl/core/affine_matrix_decompose_trs_assert.svh =====
// Assertion macros for the transform decomposition core.
`ifndef AFFINE_MATRIX_DECOMPOSE_TRS_ASSERT_SVH
`define AFFINE_MATRIX_DECOMPOSE_TRS_ASSERT_SVH
`ifndef SYNTHESIS
`define AMDT_ASSERT_IMPLY(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("implication check failed");
`define AMDT_ASSERT_NEXT(label, clk, ante, cons) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("next-cycle check failed");
`else
`define AMDT_ASSERT_IMPLY(label, clk, rst, ante, cons)
`define AMDT_ASSERT_NEXT(label, clk, ante, cons)
`endif
`endif

// ===== rtl/core/amdt_pkg.sv =====
`timescale 1ns / 1ps
package amdt_pkg;

  localparam int SQ_STEPS = 32;  // one root bit per stage
  localparam int DV_STEPS = 31;  // one quotient bit per stage

  localparam int S_IN   = 0;
  localparam int S_MUL  = 1;
  localparam int S_PART = 2;
  localparam int S_DET  = 5;
  localparam int S_SQ1  = 3;
  localparam int S_LEN  = S_SQ1 + SQ_STEPS - 1;
  localparam int S_DV1  = S_LEN + 1;
  localparam int S_Q1   = S_DV1 + DV_STEPS - 1;
  localparam int S_ROT  = S_Q1 + 1;
  localparam int S_QT   = S_ROT + 1;
  localparam int S_SQ2  = S_QT + 1;
  localparam int S_ROOT = S_SQ2 + SQ_STEPS - 1;
  localparam int S_DV2  = S_ROOT + 1;
  localparam int S_Q2   = S_DV2 + DV_STEPS - 1;
  localparam int S_OUT  = S_Q2 + 1;
  localparam int NST    = S_OUT + 1;
  localparam int XM_LEN = S_ROOT - S_QT + 1;

  // determinant terms: m[a]*m[b]*m[c], negated where flagged
  localparam int DET_A [6] = '{0, 0, 1, 1, 2, 2};
  localparam int DET_B [6] = '{4, 7, 3, 5, 3, 4};
  localparam int DET_C [6] = '{8, 5, 8, 6, 7, 6};
  localparam logic [5:0] DET_NEG = 6'b100110;

  // quaternion case: which component comes from the root
  localparam logic [1:0] QC_X = 2'd0;
  localparam logic [1:0] QC_Y = 2'd1;
  localparam logic [1:0] QC_Z = 2'd2;
  localparam logic [1:0] QC_W = 2'd3;

  localparam logic [30:0] ONE_Q30 = 31'h4000_0000;

  typedef struct packed {
    logic [63:0] rad;
    logic [35:0] rem;
    logic [31:0] q;
  } sqrt_t;

  typedef struct packed {
    logic [33:0] rem;
    logic [30:0] bits;
    logic [30:0] q;
    logic [32:0] d;
  } div_t;

  typedef struct packed {
    logic [31:0]      off_x;
    logic [31:0]      off_y;
    logic [31:0]      off_z;
    logic             negdet;
    logic [8:0]       msgn;
    logic [2:0]       lenz;
    logic [2:0][31:0] sc;
    logic [1:0]       qc;
    logic [2:0]       xsgn;
    logic [2:0]       xovf;
  } side_t;

  function automatic sqrt_t sqrt_step(sqrt_t s);
    sqrt_t o;
    logic [35:0] r;
    logic [35:0] t;
    r = {s.rem[33:0], s.rad[63:62]};
    t = {2'b00, s.q, 2'b01};
    o.rad = {s.rad[61:0], 2'b00};
    if (r >= t) begin
      o.rem = r - t;
      o.q = {s.q[30:0], 1'b1};
    end else begin
      o.rem = r;
      o.q = {s.q[30:0], 1'b0};
    end
    return o;
  endfunction

  function automatic div_t div_step(div_t s);
    div_t o;
    logic [33:0] r;
    logic ge;
    r = {s.rem[32:0], s.bits[30]};
    ge = (r >= {1'b0, s.d});
    o.rem = ge ? (r - {1'b0, s.d}) : r;
    o.bits = {s.bits[29:0], 1'b0};
    o.q = {s.q[29:0], ge};
    o.d = s.d;
    return o;
  endfunction

endpackage

// ===== rtl/core/affine_matrix_decompose_trs.sv =====
`timescale 1ns / 1ps
// Affine transform decomposition: translation, rotation quaternion, scale.
// Input channel (in_valid/in_ready) takes, when not stalled, one item per cycle:
// the 3x3 basis elem_rR_cC and the translation row offset_in_*, all signed Q16.16.
// Output channel (out_valid/out_ready) gives trans_* (Q16.16, copied),
// quat_* (unit quaternion, Q2.30) and scale_* (signed row length, Q16.16,
// saturated; sign from the 3x3 determinant).
// The line has 132 register stages. Throughput is one item per cycle while the
// receiver does not stall; that rate is set by the fully pipelined datapath:
// 32-stage square root units (three for the row lengths, one for the quaternion
// root) and 31-stage restoring dividers (nine for row normalize, three for the
// quaternion components), one bit per stage.
// Every stage holds its valid bit; the whole line advances when the last
// stage is empty or taken, so a stall by the receiver freezes all stages,
// drops in_ready, and loses or repeats nothing. Bubbles move along with it.
// Reset (rst, synchronous) clears all valid bits; data registers keep junk.
module affine_matrix_decompose_trs (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic signed [31:0] elem_r0_c0,
  input  logic signed [31:0] elem_r0_c1,
  input  logic signed [31:0] elem_r0_c2,
  input  logic signed [31:0] elem_r1_c0,
  input  logic signed [31:0] elem_r1_c1,
  input  logic signed [31:0] elem_r1_c2,
  input  logic signed [31:0] elem_r2_c0,
  input  logic signed [31:0] elem_r2_c1,
  input  logic signed [31:0] elem_r2_c2,
  input  logic signed [31:0] offset_in_x,
  input  logic signed [31:0] offset_in_y,
  input  logic signed [31:0] offset_in_z,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [31:0] trans_x,
  output logic signed [31:0] trans_y,
  output logic signed [31:0] trans_z,
  output logic signed [31:0] quat_x,
  output logic signed [31:0] quat_y,
  output logic signed [31:0] quat_z,
  output logic signed [31:0] quat_w,
  output logic signed [31:0] scale_x,
  output logic signed [31:0] scale_y,
  output logic signed [31:0] scale_z
);

  localparam int NST      = amdt_pkg::NST;
  localparam int SQ_STEPS = amdt_pkg::SQ_STEPS;
  localparam int DV_STEPS = amdt_pkg::DV_STEPS;
  localparam int S_LEN    = amdt_pkg::S_LEN;
  localparam int XM_LEN   = amdt_pkg::XM_LEN;

  logic adv;
  logic [NST-1:0] vld;

  // per-item side data that rides along every stage
  amdt_pkg::side_t side [NST];
  amdt_pkg::side_t side_in [1:NST-1];
  amdt_pkg::side_t s0;

  logic signed [31:0] in_m [9];
  logic signed [31:0] m0 [9];
  logic [31:0] magp [S_LEN+1][9];

  // determinant path; 98 bits hold the full determinant range
  logic signed [63:0] pr [6];
  logic signed [31:0] cc [6];
  logic signed [64:0] lo [6];
  logic signed [63:0] hi [6];
  logic signed [97:0] tsum [6];
  logic signed [97:0] tt [6];
  logic signed [97:0] uu [3];
  logic signed [97:0] det_total;

  // row lengths
  logic [63:0] sq [9];
  logic [63:0] rsum [3];
  amdt_pkg::sqrt_t sq1 [3][SQ_STEPS];
  amdt_pkg::sqrt_t sq1_in [3][SQ_STEPS];
  logic [31:0] len [3];

  // normalize
  amdt_pkg::div_t dv1 [9][DV_STEPS];
  amdt_pkg::div_t dv1_in [9][DV_STEPS];
  logic signed [31:0] rr [9];
  logic signed [31:0] rr_in [9];

  // quaternion
  logic [1:0] qc_c;
  logic n1, n2, n3;
  logic signed [34:0] qt_c;
  logic [32:0] qtc, qtc_in;
  logic signed [32:0] xv [3];
  logic [31:0] xm [XM_LEN][3];
  logic [31:0] xm_in [3];
  amdt_pkg::sqrt_t sq2 [SQ_STEPS];
  amdt_pkg::sqrt_t sq2_in [SQ_STEPS];
  logic [31:0] root2;
  amdt_pkg::div_t dv2 [3][DV_STEPS];
  amdt_pkg::div_t dv2_in [3][DV_STEPS];
  logic [2:0] ovf_c;
  logic signed [31:0] fpart [3];
  logic signed [31:0] quat_in [4];
  logic signed [31:0] quat_r [4];

  // whole line moves together; last stage is the output register
  assign adv = !vld[NST-1] || out_ready;
  assign in_ready = adv;
  assign out_valid = vld[NST-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (adv) begin
      vld <= {vld[NST-2:0], in_valid};
    end
  end

  assign in_m[0] = elem_r0_c0;
  assign in_m[1] = elem_r0_c1;
  assign in_m[2] = elem_r0_c2;
  assign in_m[3] = elem_r1_c0;
  assign in_m[4] = elem_r1_c1;
  assign in_m[5] = elem_r1_c2;
  assign in_m[6] = elem_r2_c0;
  assign in_m[7] = elem_r2_c1;
  assign in_m[8] = elem_r2_c2;

  always_comb begin
    s0 = '0;
    s0.off_x = offset_in_x;
    s0.off_y = offset_in_y;
    s0.off_z = offset_in_z;
    for (int e = 0; e < 9; e++) begin
      s0.msgn[e] = in_m[e][31];
    end
  end

  // stage 0 capture, magnitude line up to the normalize dividers
  always_ff @(posedge clk) begin
    if (adv) begin
      for (int e = 0; e < 9; e++) begin
        m0[e] <= in_m[e];
        magp[0][e] <= in_m[e][31] ? (32'd0 - in_m[e]) : in_m[e];
      end
      for (int g = 1; g <= S_LEN; g++) begin
        magp[g] <= magp[g-1];
      end
    end
  end

  // products, partial products of the triple terms, row sums
  always_comb begin
    for (int k = 0; k < 6; k++) begin
      tsum[k] = 98'($signed({hi[k], 32'd0})) + 98'(lo[k]);
    end
    det_total = uu[0] + uu[1] + uu[2];
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int k = 0; k < 6; k++) begin
        pr[k] <= m0[amdt_pkg::DET_A[k]] * m0[amdt_pkg::DET_B[k]];
        cc[k] <= m0[amdt_pkg::DET_C[k]];
        lo[k] <= $signed({1'b0, pr[k][31:0]}) * cc[k];
        hi[k] <= $signed(pr[k][63:32]) * cc[k];
        tt[k] <= amdt_pkg::DET_NEG[k] ? -tsum[k] : tsum[k];
      end
      for (int j = 0; j < 3; j++) begin
        uu[j] <= tt[2*j] + tt[2*j+1];
      end
      for (int e = 0; e < 9; e++) begin
        sq[e] <= m0[e] * m0[e];
      end
      for (int i = 0; i < 3; i++) begin
        rsum[i] <= sq[3*i] + sq[3*i+1] + sq[3*i+2];
      end
    end
  end

  // row length square roots
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      sq1_in[i][0] = amdt_pkg::sqrt_step('{rad: rsum[i], rem: '0, q: '0});
      for (int j = 1; j < SQ_STEPS; j++) begin
        sq1_in[i][j] = amdt_pkg::sqrt_step(sq1[i][j-1]);
      end
      len[i] = sq1[i][SQ_STEPS-1].q;
    end
  end

  // normalize dividers: |m| * 2^30 / len, quotient fits 31 bits
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        dv1_in[3*i+j][0] = amdt_pkg::div_step('{
          rem: {3'd0, magp[S_LEN][3*i+j][31:1]},
          bits: {magp[S_LEN][3*i+j][0], 30'd0},
          q: '0,
          d: {1'b0, len[i]}});
        for (int s = 1; s < DV_STEPS; s++) begin
          dv1_in[3*i+j][s] = amdt_pkg::div_step(dv1[3*i+j][s-1]);
        end
      end
    end
  end

  // signed, zero for a zero-length row
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        if (side[amdt_pkg::S_Q1].lenz[i]) begin
          rr_in[3*i+j] = '0;
        end else if (side[amdt_pkg::S_Q1].msgn[3*i+j] ^ side[amdt_pkg::S_Q1].negdet) begin
          rr_in[3*i+j] = 32'd0 - {1'b0, dv1[3*i+j][DV_STEPS-1].q};
        end else begin
          rr_in[3*i+j] = {1'b0, dv1[3*i+j][DV_STEPS-1].q};
        end
      end
    end
  end

  // case select on the diagonal, qt and the off-diagonal sums
  always_comb begin
    if (rr[8] < 0) begin
      qc_c = (rr[0] > rr[4]) ? amdt_pkg::QC_X : amdt_pkg::QC_Y;
    end else begin
      qc_c = (33'(rr[0]) < -33'(rr[4])) ? amdt_pkg::QC_Z : amdt_pkg::QC_W;
    end
    n1 = qc_c[1];
    n2 = qc_c[0];
    n3 = (qc_c == amdt_pkg::QC_X) || (qc_c == amdt_pkg::QC_W);
    qt_c = 35'sd1073741824
         - (n3 ? -35'(rr[0]) : 35'(rr[0]))
         - (n2 ? -35'(rr[4]) : 35'(rr[4]))
         - (n1 ? -35'(rr[8]) : 35'(rr[8]));
    qtc_in = (qt_c < 35'sd1) ? 33'd1 : qt_c[32:0];
    xv[0] = 33'(rr[1]) + (n1 ? -33'(rr[3]) : 33'(rr[3]));
    xv[1] = 33'(rr[6]) + (n2 ? -33'(rr[2]) : 33'(rr[2]));
    xv[2] = 33'(rr[5]) + (n3 ? -33'(rr[7]) : 33'(rr[7]));
    for (int k = 0; k < 3; k++) begin
      xm_in[k] = xv[k][32] ? 32'(-xv[k]) : xv[k][31:0];
    end
  end

  // quaternion root
  always_comb begin
    sq2_in[0] = amdt_pkg::sqrt_step('{rad: {1'b0, qtc, 30'd0}, rem: '0, q: '0});
    for (int j = 1; j < SQ_STEPS; j++) begin
      sq2_in[j] = amdt_pkg::sqrt_step(sq2[j-1]);
    end
    root2 = sq2[SQ_STEPS-1].q;
  end

  // component dividers: |x| * 2^29 / root; overflow past 31 bits flagged up front
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      ovf_c[k] = ({2'd0, xm[XM_LEN-1][k][31:2]} >= root2);
      dv2_in[k][0] = amdt_pkg::div_step('{
        rem: {4'd0, xm[XM_LEN-1][k][31:2]},
        bits: {xm[XM_LEN-1][k][1:0], 29'd0},
        q: '0,
        d: {1'b0, root2}});
      for (int s = 1; s < DV_STEPS; s++) begin
        dv2_in[k][s] = amdt_pkg::div_step(dv2[k][s-1]);
      end
    end
  end

  // clamp, sign, place by case; the root component is root / 2
  always_comb begin
    logic [30:0] qv;
    logic [1:0] idx;
    for (int k = 0; k < 3; k++) begin
      qv = dv2[k][DV_STEPS-1].q;
      if (side[amdt_pkg::S_Q2].xovf[k] || (qv > amdt_pkg::ONE_Q30)) begin
        qv = amdt_pkg::ONE_Q30;
      end
      fpart[k] = side[amdt_pkg::S_Q2].xsgn[k] ? (32'd0 - {1'b0, qv}) : {1'b0, qv};
    end
    for (int c = 0; c < 4; c++) begin
      idx = 2'(c) ^ side[amdt_pkg::S_Q2].qc;
      case (idx)
        2'd0:    quat_in[c] = {1'b0, dv2[0][DV_STEPS-1].d[31:1]};
        2'd1:    quat_in[c] = fpart[0];
        2'd2:    quat_in[c] = fpart[1];
        default: quat_in[c] = fpart[2];
      endcase
    end
  end

  // side data updates at the stage where each field is known
  always_comb begin
    for (int g = 1; g < NST; g++) begin
      side_in[g] = side[g-1];
    end
    side_in[amdt_pkg::S_DET].negdet = det_total[97];
    for (int i = 0; i < 3; i++) begin
      side_in[amdt_pkg::S_DV1].lenz[i] = (len[i] == 32'd0);
      if (side[S_LEN].negdet) begin
        side_in[amdt_pkg::S_DV1].sc[i] = (len[i] > 32'h8000_0000) ? 32'h8000_0000
                                         : (32'd0 - len[i]);
      end else begin
        side_in[amdt_pkg::S_DV1].sc[i] = (len[i] > 32'h7FFF_FFFF) ? 32'h7FFF_FFFF : len[i];
      end
    end
    side_in[amdt_pkg::S_QT].qc = qc_c;
    for (int k = 0; k < 3; k++) begin
      side_in[amdt_pkg::S_QT].xsgn[k] = xv[k][32];
    end
    side_in[amdt_pkg::S_DV2].xovf = ovf_c;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      side[0] <= s0;
      for (int g = 1; g < NST; g++) begin
        side[g] <= side_in[g];
      end
      sq1 <= sq1_in;
      dv1 <= dv1_in;
      rr <= rr_in;
      qtc <= qtc_in;
      xm[0] <= xm_in;
      for (int g = 1; g < XM_LEN; g++) begin
        xm[g] <= xm[g-1];
      end
      sq2 <= sq2_in;
      dv2 <= dv2_in;
      quat_r <= quat_in;
    end
  end

  assign trans_x = side[NST-1].off_x;
  assign trans_y = side[NST-1].off_y;
  assign trans_z = side[NST-1].off_z;
  assign scale_x = side[NST-1].sc[0];
  assign scale_y = side[NST-1].sc[1];
  assign scale_z = side[NST-1].sc[2];
  assign quat_x = quat_r[0];
  assign quat_y = quat_r[1];
  assign quat_z = quat_r[2];
  assign quat_w = quat_r[3];

`include "affine_matrix_decompose_trs_assert.svh"

  // a held result must block the input side
  `AMDT_ASSERT_IMPLY(a_stall_blocks_in, clk, rst, out_valid && !out_ready, !in_ready)
  // reset empties the line
  `AMDT_ASSERT_NEXT(a_reset_empty, clk, rst, !out_valid)
  // quaternion w stays within the unit range
  `AMDT_ASSERT_IMPLY(a_quat_range, clk, rst, out_valid,
                     (quat_w <= 32'sd1073741824) && (quat_w >= -32'sd1073741824))

endmodule
